// ===== sv/gcis_pkg.sv =====
// ----------------------------------------------------------------------------
// gcis_pkg
// Shared types and constants for the genotype call and INFO score block.
// ----------------------------------------------------------------------------
package gcis_pkg;

    // Call codes
    localparam logic [7:0] CODE_MISSING = 8'd3;
    localparam logic [7:0] CODE_HOM     = 8'd4;
    localparam logic [7:0] CODE_HET     = 8'd5;
    localparam logic [7:0] CODE_ALT     = 8'd6;

    // Item kinds carried on the input tuser bit
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TABLE  = 1'b1;

    // Accumulator limits
    localparam logic [25:0]        ASUM_MAX = 26'h3FF_FFFF;
    localparam logic [16:0]        CNT_MAX  = 17'h1_FFFF;
    localparam logic signed [39:0] VSUM_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] VSUM_MIN = 40'sh80_0000_0000;

    // Result limits
    localparam logic signed [44:0] INFO_MAX = 45'sd8388607;
    localparam logic signed [44:0] INFO_MIN = -45'sd8388608;
    localparam logic signed [44:0] Q16_ONE  = 45'sd65536;
    localparam logic [16:0]        FREQ_MAX = 17'd65536;

    // Divider widths and step counts
    localparam int DIV_DW = 52;
    localparam int DIV_QW = 42;
    localparam logic [5:0] FREQ_STEPS = 6'd17;
    localparam logic [5:0] INFO_STEPS = 6'd42;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK,
        ST_ACC,
        ST_PREP1,
        ST_PREP2,
        ST_DIVF,
        ST_ICHK,
        ST_DIVI,
        ST_FIN,
        ST_OUT
    } gcis_state_t;

    typedef struct packed {
        logic       start;
        logic [5:0] steps;
    } div_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== sv/gcis_table.sv =====
// ----------------------------------------------------------------------------
// gcis_table
// Decode table: synchronous RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module gcis_table #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/gcis_div.sv =====
// ----------------------------------------------------------------------------
// gcis_div
// Restoring divider, one quotient bit per cycle. The high part of the
// numerator must be below the divisor; the low part is shifted in MSB first.
// ----------------------------------------------------------------------------
module gcis_div
    import gcis_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  div_cmd_t          cmd,
    input  logic [DIV_DW-1:0] num_hi,
    input  logic [DIV_QW-1:0] num_lo,
    input  logic [DIV_DW-1:0] den,
    output div_stat_t         stat,
    output logic [DIV_QW-1:0] quot
);

    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_QW-1:0] lo_reg, lo_next;
    logic [DIV_QW-1:0] quot_reg, quot_next;
    logic [DIV_DW-1:0] den_reg, den_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_DW:0]   trial;
    logic              fits;

    // One trial subtraction per step
    always_comb begin
        trial = {rem_reg, lo_reg[DIV_QW-1]};
        fits  = trial >= {1'b0, den_reg};
    end

    always_comb begin
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start) begin
            rem_next  = num_hi;
            lo_next   = num_lo;
            quot_next = '0;
            den_next  = den;
            cnt_next  = cmd.steps;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? DIV_DW'(trial - {1'b0, den_reg}) : trial[DIV_DW-1:0];
            lo_next   = {lo_reg[DIV_QW-2:0], 1'b0};
            quot_next = {quot_reg[DIV_QW-2:0], fits};
            cnt_next  = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        lo_reg   <= lo_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

// ===== sv/genotype_call_and_info_score_top.sv =====
// ----------------------------------------------------------------------------
// genotype_call_and_info_score_top
// Per-sample genotype call with running INFO score and allele frequency.
// ----------------------------------------------------------------------------
// Usage: one word per sample (tuser = 0) or per table write (tuser = 1).
// A table write gives no output word. A sample's output word is loaded
// after the table read (ST_LOOK), accumulate (ST_ACC) and output load
// (ST_OUT) states, and the next word is taken in ST_IDLE after that. A
// sample marked tlast also computes the statistics through one shared
// bit-serial divider: set-up states ST_PREP1 and ST_PREP2, the frequency
// quotient in ST_DIVF, a check in ST_ICHK, the INFO quotient in ST_DIVI
// and a final state ST_FIN. One item is worked on at a time; the next is
// taken while an earlier output word still waits. A stalled output holds
// the block in ST_OUT.
// The decode table holds no defined value until written.
module genotype_call_and_info_score_top
    import gcis_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: dosage_mode
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] ploidy_byte, [15:8] prob_hom, [23:16] prob_het,
    // [39:24] random_draw, [49:40] table_index, [57:50] table_value
    input  logic [63:0] s_tdata,
    input  logic        s_tuser,   // [0] action
    input  logic        s_tlast,   // last_sample
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] call_code, [31:8] info_score, [48:32] allele_freq
    output logic [55:0] m_tdata,
    output logic [1:0]  m_tuser    // [0] stats_valid, [1] stats_undefined
);

    localparam int AW = $clog2(TABLE_DEPTH);

    gcis_state_t state_reg, state_next;

    // Input fields
    logic [7:0]  in_ploidy, in_p0, in_p1, in_tval;
    logic [15:0] in_r;
    logic [9:0]  in_tidx, in_e;

    // Held sample
    logic [7:0]  ploidy_reg, p0_reg, p1_reg;
    logic [15:0] r_reg;
    logic        last_reg;
    logic [7:0]  code_reg;
    logic signed [20:0] term_reg;
    logic        present_reg;

    // Accumulators
    logic [25:0]        asum_reg;
    logic signed [39:0] vsum_reg;
    logic [16:0]        cnt_reg;

    // Statistics working registers
    logic [25:0] c_reg;
    logic [57:0] vnum_reg;
    logic [51:0] dmag_reg;
    logic        vneg_reg, dneg_reg;
    logic [42:0] q_reg;
    logic [16:0] freq_reg;
    logic signed [23:0] info_reg;
    logic        undef_reg, stats_reg;

    // Output register
    logic        m_tvalid_reg;
    logic [55:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;
    logic        dosage_mode_reg;

    // Control
    logic        accept, out_free, out_load, tbl_we, tbl_re;
    div_cmd_t    div_cmd;
    div_stat_t   div_stat;
    logic [DIV_DW-1:0] div_hi, div_den;
    logic [DIV_QW-1:0] div_lo, div_q;
    logic [7:0]  tbl_rd;

    // Sample datapath values
    logic [9:0]  e_val;
    logic [10:0] f_val;
    logic [18:0] f255;
    logic [19:0] esq;
    logic [23:0] lhs;
    logic [7:0]  code_val;
    logic [26:0] asum_add;
    logic signed [40:0] vsum_add;
    logic [39:0] vmag;
    logic [25:0] diff;
    logic [42:0] fnum;
    logic        a_lt_c, info_undef, q_ovf;
    logic [43:0] qp;
    logic signed [44:0] tt, info_full;

    assign in_ploidy = s_tdata[7:0];
    assign in_p0     = s_tdata[15:8];
    assign in_p1     = s_tdata[23:16];
    assign in_r      = s_tdata[39:24];
    assign in_tidx   = s_tdata[49:40];
    assign in_tval   = s_tdata[57:50];
    assign in_e      = {1'b0, in_p0, 1'b0} + {2'b0, in_p1};

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // Decode table
    gcis_table #(.DEPTH(TABLE_DEPTH)) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_we),
        .wr_addr (in_tidx[AW-1:0]),
        .wr_data (in_tval),
        .rd_en   (tbl_re),
        .rd_addr (in_e[AW-1:0]),
        .rd_data (tbl_rd)
    );

    // Shared divider
    gcis_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (div_cmd),
        .num_hi  (div_hi),
        .num_lo  (div_lo),
        .den     (div_den),
        .stat    (div_stat),
        .quot    (div_q)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_tuser == ACT_SAMPLE) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:  state_next = ST_ACC;
            ST_ACC:   state_next = last_reg ? ST_PREP1 : ST_OUT;
            ST_PREP1: state_next = ST_PREP2;
            ST_PREP2: begin
                if (c_reg == '0) begin
                    state_next = ST_FIN;
                end else if (a_lt_c) begin
                    state_next = ST_DIVF;
                end else begin
                    state_next = ST_ICHK;
                end
            end
            ST_DIVF: begin
                if (div_stat.done) begin
                    state_next = ST_ICHK;
                end
            end
            ST_ICHK: begin
                if (info_undef || q_ovf) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_DIVI;
                end
            end
            ST_DIVI: begin
                if (div_stat.done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_tready      = 1'b0;
        tbl_we        = 1'b0;
        tbl_re        = 1'b0;
        out_load      = 1'b0;
        div_cmd.start = 1'b0;
        div_cmd.steps = FREQ_STEPS;
        div_hi        = '0;
        div_lo        = '0;
        div_den       = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                tbl_we   = s_tvalid && s_tuser == ACT_TABLE
                           && 32'(in_tidx) < TABLE_DEPTH;
                tbl_re   = s_tvalid && s_tuser == ACT_SAMPLE;
            end
            ST_PREP2: begin
                div_cmd.start = c_reg != '0 && a_lt_c;
                div_cmd.steps = FREQ_STEPS;
                div_hi        = DIV_DW'(fnum[42:17]);
                div_lo        = {fnum[16:0], 25'b0};
                div_den       = DIV_DW'(c_reg);
            end
            ST_ICHK: begin
                div_cmd.start = !info_undef && !q_ovf;
                div_cmd.steps = INFO_STEPS;
                div_hi        = DIV_DW'(vnum_reg[57:25]);
                div_lo        = {vnum_reg[24:0], 17'b0};
                div_den       = dmag_reg;
            end
            ST_OUT: out_load = out_free;
            default: begin
            end
        endcase
    end

    // Sample arithmetic
    always_comb begin
        e_val    = {1'b0, p0_reg, 1'b0} + {2'b0, p1_reg};
        f_val    = {1'b0, p0_reg, 2'b0} + {3'b0, p1_reg};
        f255     = {f_val, 8'b0} - {8'b0, f_val};
        esq      = e_val * e_val;
        lhs      = {r_reg, 8'b0} - {8'b0, r_reg};
        if (ploidy_reg[7]) begin
            code_val = CODE_MISSING;
        end else if (dosage_mode_reg) begin
            code_val = (32'(e_val) < TABLE_DEPTH) ? tbl_rd : 8'd0;
        end else if (lhs < {p0_reg, 16'b0}) begin
            code_val = CODE_HOM;
        end else if ({1'b0, lhs} < {({1'b0, p0_reg} + {1'b0, p1_reg}), 16'b0}) begin
            code_val = CODE_HET;
        end else begin
            code_val = CODE_ALT;
        end
        asum_add = {1'b0, asum_reg} + {17'b0, e_val};
        vsum_add = {vsum_reg[39], vsum_reg} + {{20{term_reg[20]}}, term_reg};
    end

    // Statistics arithmetic
    always_comb begin
        vmag       = vsum_reg[39] ? 40'(~vsum_reg + 40'sd1) : vsum_reg;
        a_lt_c     = asum_reg < c_reg;
        diff       = a_lt_c ? c_reg - asum_reg : asum_reg - c_reg;
        fnum       = {1'b0, diff, 16'b0} + {18'b0, c_reg[25:1]};
        info_undef = asum_reg == '0 || asum_reg == c_reg;
        q_ovf      = {19'b0, vnum_reg[57:25]} >= dmag_reg;
        qp         = {1'b0, q_reg} + 44'd1;
        tt         = {2'b0, qp[43:1]};
        info_full  = Q16_ONE - ((vneg_reg != dneg_reg) ? -tt : tt);
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                ploidy_reg <= in_ploidy;
                p0_reg     <= in_p0;
                p1_reg     <= in_p1;
                r_reg      <= in_r;
                last_reg   <= s_tlast;
                stats_reg  <= 1'b0;
                undef_reg  <= 1'b0;
                info_reg   <= '0;
                freq_reg   <= '0;
            end
            ST_LOOK: begin
                code_reg    <= code_val;
                present_reg <= !ploidy_reg[7];
                term_reg    <= $signed({2'b0, f255}) - $signed({1'b0, esq});
            end
            ST_PREP1: begin
                c_reg     <= {9'b0, cnt_reg} * 26'd510;
                vnum_reg  <= vmag * {cnt_reg, 1'b0};
                vneg_reg  <= vsum_reg[39];
                stats_reg <= 1'b1;
            end
            ST_PREP2: begin
                dmag_reg <= asum_reg * diff;
                dneg_reg <= !a_lt_c;
                if (c_reg == '0) begin
                    undef_reg <= 1'b1;
                end
            end
            ST_DIVF: begin
                if (div_stat.done) begin
                    freq_reg <= (div_q[16:0] > FREQ_MAX) ? FREQ_MAX : div_q[16:0];
                end
            end
            ST_ICHK: begin
                if (info_undef) begin
                    undef_reg <= 1'b1;
                end
                q_reg <= {1'b1, 42'b0};
            end
            ST_DIVI: begin
                if (div_stat.done) begin
                    q_reg <= {1'b0, div_q};
                end
            end
            ST_FIN: begin
                if (!undef_reg) begin
                    if (info_full > INFO_MAX) begin
                        info_reg <= 24'sh7F_FFFF;
                    end else if (info_full < INFO_MIN) begin
                        info_reg <= 24'sh80_0000;
                    end else begin
                        info_reg <= info_full[23:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers, accumulators and output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            dosage_mode_reg <= 1'b1;
            asum_reg        <= '0;
            vsum_reg        <= '0;
            cnt_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                dosage_mode_reg <= cfg_data;
            end
            // Accumulate a present sample, saturating each sum
            if (state_reg == ST_ACC && present_reg) begin
                asum_reg <= asum_add[26] ? ASUM_MAX : asum_add[25:0];
                if (vsum_add[40] != vsum_add[39]) begin
                    vsum_reg <= vsum_add[40] ? VSUM_MIN : VSUM_MAX;
                end else begin
                    vsum_reg <= vsum_add[39:0];
                end
                if (cnt_reg != CNT_MAX) begin
                    cnt_reg <= cnt_reg + 17'd1;
                end
            end
            // Drop the sums once the variant is reported
            if (out_load && last_reg) begin
                asum_reg <= '0;
                vsum_reg <= '0;
                cnt_reg  <= '0;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (out_load) begin
            m_tdata_reg <= {7'b0, freq_reg, info_reg, code_reg};
            m_tuser_reg <= {undef_reg, stats_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Non-final words carry no statistics
    a_no_stats: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[48:8] == '0 && !m_tuser[1]))
        else $error("statistics on a non-final word");

    // Frequency stays within one in Q16
    a_freq_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[48:32] <= FREQ_MAX))
        else $error("allele frequency out of range");

    // Divider only started when free
    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_cmd.start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    // Sums cleared after a reported variant
    a_sums_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && last_reg) |=> (asum_reg == '0 && cnt_reg == '0 && vsum_reg == '0))
        else $error("sums not cleared after final sample");

endmodule
